@@ hdl/hdnw_pkg.sv @@
// Shared types and constants for the HD44780 four-bit nibble writer.
// Used by hdnw_pulse_gen, hd44780_nibble_writer and hdnw_checker; no dependencies.
`default_nettype none

package hdnw_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [2:0] {
		OP_CMD    = 3'd0,
		OP_DATA   = 3'd1,
		OP_GOTO   = 3'd2,
		OP_NUMBER = 3'd3,
		OP_INIT   = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_FUNCTION_SET = 2'd0,
		CFG_DISPLAY_CTRL = 2'd1,
		CFG_ENTRY_MODE   = 2'd2
	} cfg_idx_t;

	localparam int MAX_COLUMNS_DEF = 40;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
	localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0E;
	localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] DDRAM_LINE2    = 8'h40;
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
	localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIB   = 4'h2;

	localparam logic [7:0] BYTE_WAIT     = 8'd2;
	localparam logic [7:0] INIT_CMD_WAIT = 8'd250;
	localparam logic [7:0] WAKE_WAIT_0   = 8'd40;
	localparam logic [7:0] WAKE_WAIT_A   = 8'd5;

	localparam int          NUM_W   = 14;
	localparam logic [15:0] NUM_MAX = 16'd9999;

	// pulse index of the final pulse for each kind of run
	localparam logic [3:0] LAST_BYTE   = 4'd1;
	localparam logic [3:0] LAST_NUMBER = 4'd7;
	localparam logic [3:0] LAST_INIT   = 4'd13;

	// one enable pulse, without the end-of-run mark
	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic [7:0] wait_before;
		logic [7:0] wait_after;
	} pulse_t;

	// power-up commands as written through the config port
	typedef struct packed {
		logic [7:0] function_set;
		logic [7:0] display_ctrl;
		logic [7:0] entry_mode;
	} init_cmds_t;

endpackage

`default_nettype wire

@@ hdl/hd44780_nibble_writer.sv @@
// Top level of the HD44780 four-bit nibble writer: request register, pulse sequencer,
// output register and config registers. Depends on hdnw_pkg and hdnw_pulse_gen.
//
// Each accepted request is played out as a run of enable-pulse words, one word per
// clock while the output side takes them: a command or data byte or a goto gives 2
// words, a number 8, the power-up sequence 14; an unknown op or a goto to a column
// not below MAX_COLUMNS gives none. The pulse counter sets the pace, and the next
// request is accepted in the cycle its predecessor's last word enters the output
// register. A number above 9999 is shown as 9999; its digits are peeled off one per
// byte by a compare bank and a subtract on a remainder register. The three power-up
// commands are read from the config registers when the words go out, so write them
// only while the block is idle. tlast marks the final word of each run.
`default_nettype none

module hd44780_nibble_writer #(
	parameter int MAX_COLUMNS = hdnw_pkg::MAX_COLUMNS_DEF
) (
	input  var logic                               clk,
	input  var logic                               arst_n,
	// request stream
	input  var logic                               s_axis_tvalid,
	output logic                                   s_axis_tready,
	// byte_value[7:0], column[15:8], row[16], number[32:17], zero [39:33]
	input  var logic [hdnw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op[2:0]
	input  var logic [2:0]                         s_axis_tuser,
	// pulse stream
	output logic                                   m_axis_tvalid,
	input  var logic                               m_axis_tready,
	// nibble[3:0], wait_before[11:4], wait_after[19:12], zero [23:20]
	output logic [hdnw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// reg_select[0]
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast,
	// config write channel
	input  var logic                               cfg_valid,
	output logic                                   cfg_ready,
	input  var logic [1:0]                         cfg_index,
	input  var logic [7:0]                         cfg_data
);
	import hdnw_pkg::*;

	localparam logic [8:0] MaxCol = 9'(MAX_COLUMNS);

	// request fields
	op_t              in_op;
	logic [7:0]       in_byte;
	logic [7:0]       in_column;
	logic             in_row;
	logic [15:0]      in_number;
	logic             in_has_pulses;
	logic [7:0]       in_goto_cmd;
	logic             accept;

	// sequencer
	logic             busy_q;
	op_t              op_q;
	logic [7:0]       byte_q;
	logic [NUM_W-1:0] rem_q;
	logic [3:0]       idx_q;
	logic [3:0]       last_idx_q;
	init_cmds_t       cmds_q;
	logic             emit;
	logic             finish;
	pulse_t           pulse;
	logic [NUM_W-1:0] digit_sub;

	// output register
	logic             out_valid_q;
	pulse_t           out_pulse_q;
	logic             out_last_q;

	assign in_op     = op_t'(s_axis_tuser);
	assign in_byte   = s_axis_tdata[7:0];
	assign in_column = s_axis_tdata[15:8];
	assign in_row    = s_axis_tdata[16];
	assign in_number = s_axis_tdata[32:17];

	assign in_goto_cmd = CMD_SET_DDRAM | (in_row ? DDRAM_LINE2 : 8'h00) | in_column;

	// which requests produce any words
	always_comb begin
		case (in_op)
			OP_CMD, OP_DATA, OP_NUMBER, OP_INIT: in_has_pulses = 1'b1;
			OP_GOTO: in_has_pulses = ({1'b0, in_column} < MaxCol);
			default: in_has_pulses = 1'b0;
		endcase
	end

	// handshake
	assign emit          = busy_q && (!out_valid_q || m_axis_tready);
	assign finish        = emit && (idx_q == last_idx_q);
	assign s_axis_tready = !busy_q || finish;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	hdnw_pulse_gen u_pulse_gen (
		.op         (op_q),
		.byte_value (byte_q),
		.remainder  (rem_q),
		.idx        (idx_q),
		.cmds       (cmds_q),
		.pulse      (pulse),
		.digit_sub  (digit_sub)
	);

	// sequencer: load a request, then step through its words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (accept) begin
			busy_q <= in_has_pulses;
			idx_q  <= 4'd0;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			byte_q <= (in_op == OP_GOTO) ? in_goto_cmd : in_byte;
			rem_q  <= (in_number > NUM_MAX) ? NUM_MAX[NUM_W-1:0] : in_number[NUM_W-1:0];
			case (in_op)
				OP_NUMBER: last_idx_q <= LAST_NUMBER;
				OP_INIT:   last_idx_q <= LAST_INIT;
				default:   last_idx_q <= LAST_BYTE;
			endcase
		end else if (emit && idx_q[0] && op_q == OP_NUMBER) begin
			rem_q <= rem_q - digit_sub;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmds_q.function_set <= FUNCTION_SET_RST;
			cmds_q.display_ctrl <= DISPLAY_CTRL_RST;
			cmds_q.entry_mode   <= ENTRY_MODE_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FUNCTION_SET: cmds_q.function_set <= cfg_data;
				CFG_DISPLAY_CTRL: cmds_q.display_ctrl <= cfg_data;
				CFG_ENTRY_MODE:   cmds_q.entry_mode   <= cfg_data;
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pulse_q <= pulse;
			out_last_q  <= (idx_q == last_idx_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_pulse_q.wait_after, out_pulse_q.wait_before,
		out_pulse_q.nibble};
	assign m_axis_tuser  = out_pulse_q.rs;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ hdl/hdnw_pulse_gen.sv @@
// Forms one enable pulse from the request being played out and its pulse index.
// Also extracts the current decimal digit of a number. Depends on hdnw_pkg.
`default_nettype none

module hdnw_pulse_gen (
	input  var hdnw_pkg::op_t                    op,
	input  var logic [7:0]                       byte_value,
	input  var logic [hdnw_pkg::NUM_W-1:0]       remainder,
	input  var logic [3:0]                       idx,
	input  var hdnw_pkg::init_cmds_t             cmds,
	output hdnw_pkg::pulse_t                     pulse,
	output logic [hdnw_pkg::NUM_W-1:0]           digit_sub
);
	import hdnw_pkg::*;

	logic [3:0]       digit;
	logic [NUM_W-1:0] thr;
	logic [3:0]       init_k;
	logic [7:0]       init_byte;

	// current digit: count of place-value steps that fit in the remainder
	always_comb begin
		digit     = 4'd0;
		digit_sub = '0;
		for (int k = 1; k <= 9; k++) begin
			case (idx[2:1])
				2'd0:    thr = NUM_W'(k * 1000);
				2'd1:    thr = NUM_W'(k * 100);
				2'd2:    thr = NUM_W'(k * 10);
				default: thr = NUM_W'(k);
			endcase
			if (remainder >= thr) begin
				digit     = 4'(k);
				digit_sub = thr;
			end
		end
	end

	// command byte of the power-up tail
	always_comb begin
		init_k = idx - 4'd4;
		case (init_k[3:1])
			3'd0:    init_byte = cmds.function_set;
			3'd1:    init_byte = cmds.display_ctrl;
			3'd2:    init_byte = CMD_CLEAR;
			3'd3:    init_byte = cmds.entry_mode;
			default: init_byte = CMD_SET_DDRAM;
		endcase
	end

	// pulse fields
	always_comb begin
		pulse.rs          = 1'b0;
		pulse.nibble      = idx[0] ? byte_value[3:0] : byte_value[7:4];
		pulse.wait_before = 8'd0;
		pulse.wait_after  = BYTE_WAIT;
		case (op)
			OP_DATA: begin
				pulse.rs = 1'b1;
			end
			OP_NUMBER: begin
				pulse.rs     = 1'b1;
				pulse.nibble = idx[0] ? digit : ASCII_DIGIT_HI;
			end
			OP_INIT: begin
				case (idx)
					4'd0: begin
						pulse.nibble      = WAKE_NIBBLE;
						pulse.wait_before = WAKE_WAIT_0;
						pulse.wait_after  = WAKE_WAIT_A;
					end
					4'd1: begin
						pulse.nibble     = WAKE_NIBBLE;
						pulse.wait_after = WAKE_WAIT_A;
					end
					4'd2: begin
						pulse.nibble = WAKE_NIBBLE;
					end
					4'd3: begin
						pulse.nibble     = FOUR_BIT_NIB;
						pulse.wait_after = 8'd0;
					end
					default: begin
						pulse.nibble     = init_k[0] ? init_byte[3:0] : init_byte[7:4];
						pulse.wait_after = init_k[0] ? BYTE_WAIT + INIT_CMD_WAIT : BYTE_WAIT;
					end
				endcase
			end
			default: begin
				// command byte and goto use the defaults
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/hdnw_checker.sv @@
// Port-level checks for the HD44780 nibble writer, bound to the top level.
// Depends on hdnw_pkg; sees only the ports of hd44780_nibble_writer.
`default_nettype none

module hdnw_checker (
	input  var logic                               clk,
	input  var logic                               arst_n,
	input  var logic                               m_axis_tvalid,
	input  var logic                               m_axis_tready,
	input  var logic [hdnw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  var logic                               m_axis_tuser,
	input  var logic                               m_axis_tlast
);
	import hdnw_pkg::*;

	logic [3:0] nib;
	logic [7:0] wb;
	logic [7:0] wa;

	assign nib = m_axis_tdata[3:0];
	assign wb  = m_axis_tdata[11:4];
	assign wa  = m_axis_tdata[19:12];

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// only the first wake-up pulse waits before enable
	a_wait_before: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && wb != 8'd0 |-> wb == WAKE_WAIT_0 && nib == WAKE_NIBBLE
			&& !m_axis_tuser && wa == WAKE_WAIT_A && !m_axis_tlast)
		else $error("unexpected wait before enable");

	// data words always use the plain byte waits
	a_data_waits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> wb == 8'd0 && wa == BYTE_WAIT)
		else $error("data word with wrong waits");

	// zero wait after only on the four-bit switch pulse
	a_switch_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && wa == 8'd0 |-> nib == FOUR_BIT_NIB && !m_axis_tuser
			&& !m_axis_tlast && wb == 8'd0)
		else $error("zero wait after on a pulse other than the mode switch");

endmodule

bind hd44780_nibble_writer hdnw_checker u_hdnw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ verif/hdnw_tb_pkg.sv @@
// Scoreboard for the HD44780 nibble writer testbench: predicts the pulse words of each request.
// Depends on hdnw_pkg for request kinds, register indexes and timing constants.
package hdnw_tb_pkg;

	import hdnw_pkg::*;

	// request kinds and register index that the block ignores
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam logic [1:0] CFG_UNUSED   = 2'd3;

	// one enable pulse word as seen on the output stream
	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic [7:0] wait_before;
		logic [7:0] wait_after;
		logic       last;
	} lcd_pulse_t;

	class pulse_ledger;
		lcd_pulse_t  pending_pulses[$];
		lcd_pulse_t  run[$];
		logic [7:0]  function_set;
		logic [7:0]  display_ctrl;
		logic [7:0]  entry_mode;
		int unsigned mismatches;

		function new();
			function_set = FUNCTION_SET_RST;
			display_ctrl = DISPLAY_CTRL_RST;
			entry_mode   = ENTRY_MODE_RST;
			mismatches   = 0;
		endfunction

		function int unsigned pending();
			return pending_pulses.size();
		endfunction

		// mirror of a config word taken by the block
		function void set_reg(logic [1:0] index, logic [7:0] value);
			case (index)
				CFG_FUNCTION_SET: function_set = value;
				CFG_DISPLAY_CTRL: display_ctrl = value;
				CFG_ENTRY_MODE:   entry_mode   = value;
				default: ;
			endcase
		endfunction

		function void add_pulse(logic rs, logic [3:0] nib, logic [7:0] wb, logic [7:0] wa);
			lcd_pulse_t p;
			p.rs          = rs;
			p.nibble      = nib;
			p.wait_before = wb;
			p.wait_after  = wa;
			p.last        = 1'b0;
			run.push_back(p);
		endfunction

		// a byte goes out high nibble first
		function void add_byte(logic rs, logic [7:0] b, logic [7:0] extra);
			add_pulse(rs, b[7:4], 8'd0, BYTE_WAIT);
			add_pulse(rs, b[3:0], 8'd0, BYTE_WAIT + extra);
		endfunction

		// expand one accepted request into its run of pulse words
		function void note_request(logic [2:0] op, logic [7:0] byte_value, logic [7:0] column,
		                           logic row, logic [15:0] number);
			logic [15:0] shown;
			lcd_pulse_t  tail;
			run.delete();
			case (op)
				OP_CMD:  add_byte(1'b0, byte_value, 8'd0);
				OP_DATA: add_byte(1'b1, byte_value, 8'd0);
				OP_GOTO: begin
					// columns past the line are dropped
					if (column < MAX_COLUMNS_DEF)
						add_byte(1'b0, CMD_SET_DDRAM | (row ? DDRAM_LINE2 : 8'h00) | column, 8'd0);
				end
				OP_NUMBER: begin
					shown = (number > NUM_MAX) ? NUM_MAX : number;
					add_byte(1'b1, 8'(16'h30 + shown / 1000), 8'd0);
					add_byte(1'b1, 8'(16'h30 + (shown % 1000) / 100), 8'd0);
					add_byte(1'b1, 8'(16'h30 + (shown % 100) / 10), 8'd0);
					add_byte(1'b1, 8'(16'h30 + shown % 10), 8'd0);
				end
				OP_INIT: begin
					add_pulse(1'b0, WAKE_NIBBLE, WAKE_WAIT_0, WAKE_WAIT_A);
					add_pulse(1'b0, WAKE_NIBBLE, 8'd0, WAKE_WAIT_A);
					add_pulse(1'b0, WAKE_NIBBLE, 8'd0, BYTE_WAIT);
					add_pulse(1'b0, FOUR_BIT_NIB, 8'd0, 8'd0);
					add_byte(1'b0, function_set, INIT_CMD_WAIT);
					add_byte(1'b0, display_ctrl, INIT_CMD_WAIT);
					add_byte(1'b0, CMD_CLEAR, INIT_CMD_WAIT);
					add_byte(1'b0, entry_mode, INIT_CMD_WAIT);
					add_byte(1'b0, CMD_SET_DDRAM, INIT_CMD_WAIT);
				end
				default: ;
			endcase
			if (run.size() > 0) begin
				tail = run.pop_back();
				tail.last = 1'b1;
				run.push_back(tail);
			end
			foreach (run[i])
				pending_pulses.push_back(run[i]);
		endfunction

		// compare one output word against the oldest prediction
		function void check_pulse(logic rs, logic [3:0] nib, logic [7:0] wb, logic [7:0] wa,
		                          logic last);
			lcd_pulse_t want;
			if (pending_pulses.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: pulse word with none expected: rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
					         $time, rs, nib, wb, wa, last);
				mismatches++;
				return;
			end
			want = pending_pulses.pop_front();
			if (want.rs !== rs || want.nibble !== nib || want.wait_before !== wb ||
			    want.wait_after !== wa || want.last !== last) begin
				if (mismatches < 10) begin
					$display("%0t: pulse mismatch exp rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
					         $time, want.rs, want.nibble, want.wait_before, want.wait_after,
					         want.last);
					$display("%0t:                got rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
					         $time, rs, nib, wb, wa, last);
				end
				mismatches++;
			end
		endfunction
	endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for hd44780_nibble_writer: drives requests and config writes,
// checks every pulse word against pulse_ledger. Depends on hdnw_pkg and hdnw_tb_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hdnw_pkg::*;
	import hdnw_tb_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// byte_value[7:0], column[15:8], row[16], number[32:17], zero [39:33]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// op[2:0]
	logic [2:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// nibble[3:0], wait_before[11:4], wait_after[19:12], zero [23:20]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// reg_select[0]
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [7:0]             cfg_data = '0;

	int unsigned send_idle = 33;
	int unsigned recv_idle = 80;

	pulse_ledger ledger = new();

	hd44780_nibble_writer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// output side back-pressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// check every word taken from the output
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_pulse(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
			                   m_axis_tdata[19:12], m_axis_tlast);
	end

	// drop valid and hold until every predicted word has come out
	task automatic drain_pulses();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	// one request word, with random gaps in front
	task automatic send_request(logic [2:0] op, logic [7:0] byte_value, logic [7:0] column,
	                            logic row, logic [15:0] number);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, number, row, column, byte_value};
		do
			@(posedge clk);
		while (!s_axis_tready);
		ledger.note_request(op, byte_value, column, row, number);
	endtask

	// config word, only once the block has gone quiet
	task automatic write_reg(logic [1:0] index, logic [7:0] value);
		drain_pulses();
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		ledger.set_reg(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_init_cmds(logic [7:0] fs, logic [7:0] dc, logic [7:0] em);
		write_reg(CFG_FUNCTION_SET, fs);
		write_reg(CFG_DISPLAY_CTRL, dc);
		write_reg(CFG_ENTRY_MODE, em);
	endtask

	// random request, mostly well-formed with random content
	task automatic random_request();
		int unsigned pick;
		logic [2:0]  op;
		logic [7:0]  column;
		logic [15:0] number;
		pick = $urandom_range(99);
		if (pick < 9)
			op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
		else
			op = 3'($urandom_range(OP_INIT, OP_CMD));
		column = ($urandom_range(3) != 0) ? 8'($urandom_range(MAX_COLUMNS_DEF - 1))
		                                  : 8'($urandom_range(255));
		number = $urandom_range(1) ? 16'($urandom_range(9999)) : 16'($urandom_range(65535));
		send_request(op, 8'($urandom_range(255)), column, 1'($urandom_range(1)), number);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset commands, byte extremes, goto edges, number edges
		send_request(OP_INIT, 8'h00, 8'h00, 1'b0, 16'd0);
		send_request(OP_CMD, 8'h00, 8'hFF, 1'b1, 16'hFFFF);
		send_request(OP_CMD, 8'hFF, 8'h00, 1'b0, 16'h0000);
		send_request(OP_DATA, 8'h00, 8'h00, 1'b0, 16'd0);
		send_request(OP_DATA, 8'hFF, 8'h00, 1'b0, 16'd0);
		send_request(OP_DATA, 8'h5A, 8'h00, 1'b0, 16'd0);
		send_request(OP_GOTO, 8'h00, 8'd0, 1'b0, 16'd0);
		send_request(OP_GOTO, 8'h00, 8'(MAX_COLUMNS_DEF - 1), 1'b1, 16'd0);
		// columns off the end of the line
		send_request(OP_GOTO, 8'h00, 8'(MAX_COLUMNS_DEF), 1'b0, 16'd0);
		send_request(OP_GOTO, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd0);
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd9999);
		// saturation above four digits
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd10000);
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'hFFFF);
		// hundreds digit of 0, 1 and 9
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd5018);
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd2107);
		send_request(OP_NUMBER, 8'h00, 8'h00, 1'b0, 16'd907);
		// unknown ops give nothing
		send_request(OP_UNUSED_LO, 8'hFF, 8'h05, 1'b1, 16'd42);
		send_request(3'(OP_UNUSED_LO + 1), 8'h00, 8'h05, 1'b0, 16'd42);
		send_request(OP_UNUSED_HI, 8'hFF, 8'h05, 1'b1, 16'd42);
		drain_pulses();
		send_request(OP_CMD, 8'hC3, 8'h00, 1'b0, 16'd0);

		// power-up with extreme commands; unused index must not disturb them
		write_init_cmds(8'hFF, 8'h00, 8'hFF);
		write_reg(CFG_UNUSED, 8'h55);
		send_request(OP_INIT, 8'h00, 8'h00, 1'b0, 16'd0);
		write_init_cmds(8'h00, 8'hFF, 8'h00);
		send_request(OP_INIT, 8'h00, 8'h00, 1'b0, 16'd0);

		// random phases: receiver idles, then sender idles, then none
		for (int phase = 0; phase < 3; phase++) begin
			write_init_cmds(8'($urandom_range(255)), 8'($urandom_range(255)),
			                8'($urandom_range(255)));
			write_reg(CFG_UNUSED, 8'($urandom_range(255)));
			case (phase)
				0: begin
					send_idle = 33;
					recv_idle = 80;
				end
				1: begin
					send_idle = 80;
					recv_idle = 33;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int n = 0; n < 96; n++) begin
				if ($urandom_range(29) == 0)
					drain_pulses();
				random_request();
			end
		end

		drain_pulses();
		repeat (20) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
